FILE: rtl/core/nand_page_read_sequencer_core_assert.svh
// Assertion macros shared by the sequencer RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef NAND_PAGE_READ_SEQUENCER_CORE_ASSERT_SVH
`define NAND_PAGE_READ_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nprs_pkg.sv
`default_nettype none

package nprs_pkg;

    // Field widths of the request and result channels.
    localparam int REQ_TYPE_W   = 2;
    localparam int ADDR_W       = 29;
    localparam int COUNT_W      = 30;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 3;

    // Large-page geometry.
    localparam int PAGE_BYTES   = 2048;
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int PAGES_W      = COUNT_W - PAGE_BITS;
    localparam int ROW_W        = ADDR_W - PAGE_BITS;

    // Size of the address space; larger counts are clipped to it.
    localparam logic [COUNT_W-1:0] ADDR_SPAN = COUNT_W'(1) << ADDR_W;

    // Longest burst of results one request can cause.
    localparam int MAX_RESULTS  = 8;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

    // Flash command opcodes.
    localparam logic [BYTE_W-1:0] CMD_READ         = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_READ_CONFIRM = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_RESET        = 8'hFF;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_READY = 2'd2,
        REQ_DATA  = 2'd3
    } req_kind_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SELECT   = 3'd0,
        KIND_CMD      = 3'd1,
        KIND_ADDR     = 3'd2,
        KIND_DATA     = 3'd3,
        KIND_DESELECT = 3'd4
    } cycle_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        cycle_kind_t         kind;
        logic [BYTE_W-1:0]   value;
    } bus_cycle_t;

endpackage

`default_nettype wire

FILE: rtl/core/nprs_req_if.sv
`default_nettype none

interface nprs_req_if;
    import nprs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [ADDR_W-1:0]       start_addr;
    logic [COUNT_W-1:0]      byte_count;
    logic                    flash_ready;
    logic [BYTE_W-1:0]       flash_byte;

    modport source (
        output valid, req_type, start_addr, byte_count, flash_ready, flash_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, start_addr, byte_count, flash_ready, flash_byte,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/nprs_rsp_if.sv
`default_nettype none

interface nprs_rsp_if;
    import nprs_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   cycle_kind;
    logic [BYTE_W-1:0]   bus_value;
    logic                last;

    modport source (
        output valid, cycle_kind, bus_value, last,
        input  ready
    );

    modport sink (
        input  valid, cycle_kind, bus_value, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/nand_page_read_sequencer_core.sv
`default_nettype none

// Large-page NAND read and reset sequencer. Each request on req (read, reset,
// ready sample or data byte) turns into zero to eight flash bus cycles on rsp:
// a read selects the chip and, for every 2048-byte page, issues 00h, five
// address bytes (column low, column high, row low, row middle, row top) and
// 30h, then waits for a ready sample and forwards the page's data bytes; after
// the last page it deselects. A reset request gives select and FFh, and the
// next ready sample gives deselect. Byte counts round up to whole pages and
// are clipped to the 2^29-byte space; a zero count gives select and deselect.
// Requests that do not fit the current phase, and ready samples that report
// busy, cause no bus cycle. The last flag marks the final bus cycle of each
// request. Timing: a request is registered on acceptance and processed once
// the result buffer is free, when its whole burst of bus cycles is loaded
// into that buffer; its front entry is on the bus. The buffer shifts out one
// bus cycle per cycle while rsp is ready, so requests that cause one bus
// cycle (the data stream) or none are taken at one per cycle, and a request
// that causes more holds later ones until its last bus cycle is taken. The
// input register lets one new request in while the result buffer is stalled.
module nand_page_read_sequencer_core (
    input  wire          clk,
    input  wire          rst_n,
    nprs_req_if.sink     req,
    nprs_rsp_if.source   rsp
);
    import nprs_pkg::*;

    // Input register. The page count is worked out on the way in so that a read's
    // end address needs only one add in processing.
    logic                   in_valid_reg;
    req_kind_t              in_kind_reg;
    logic [ADDR_W-1:0]      in_start_reg;
    logic [PAGES_W-1:0]     in_pages_reg;
    logic                   in_ready_reg;
    logic [BYTE_W-1:0]      in_byte_reg;

    logic [COUNT_W-1:0]     clipped_count;
    logic [PAGES_W-1:0]     req_pages;

    // Sequencer state.
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   resetting_reg;
    logic                   resetting_next;
    logic [ADDR_W-1:0]      page_address_reg;
    logic [ADDR_W-1:0]      page_address_next;
    logic [COUNT_W-1:0]     end_address_reg;
    logic [COUNT_W-1:0]     end_address_next;
    logic [PAGE_BITS-1:0]   bytes_in_page_reg;
    logic [PAGE_BITS-1:0]   bytes_in_page_next;

    // Result buffer: entry zero is on the bus, the rest shift down behind it.
    bus_cycle_t             burst_reg [MAX_RESULTS];
    bus_cycle_t             burst_next [MAX_RESULTS];
    logic [CNT_W-1:0]       burst_cnt_reg;
    logic [CNT_W-1:0]       burst_cnt_next;

    logic                   rsp_fire;
    logic                   burst_free;
    logic                   advance;

    logic [COUNT_W-1:0]     read_end;
    logic [COUNT_W-1:0]     next_page;
    logic [ADDR_W-1:0]      hdr_addr;
    logic                   use_hdr;
    logic [PAGE_BITS-1:0]   hdr_col;
    logic [ROW_W-1:0]       hdr_row;

    // Handshake.
    assign rsp_fire   = rsp.valid && rsp.ready;
    assign burst_free = (burst_cnt_reg == '0) || (rsp_fire && burst_cnt_reg == CNT_W'(1));
    assign advance    = in_valid_reg && burst_free;
    assign req.ready  = !in_valid_reg || advance;

    assign rsp.valid      = (burst_cnt_reg != '0);
    assign rsp.cycle_kind = burst_reg[0].kind;
    assign rsp.bus_value  = burst_reg[0].value;
    assign rsp.last       = (burst_cnt_reg == CNT_W'(1));

    // Counts beyond the address space are clipped, then rounded up to pages.
    assign clipped_count = (req.byte_count > ADDR_SPAN) ? ADDR_SPAN : req.byte_count;
    assign req_pages     = clipped_count[COUNT_W-1:PAGE_BITS]
                         + PAGES_W'(|clipped_count[PAGE_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_kind_reg  <= req_kind_t'(req.req_type);
            in_start_reg <= req.start_addr;
            in_pages_reg <= req_pages;
            in_ready_reg <= req.flash_ready;
            in_byte_reg  <= req.flash_byte;
        end
    end

    // Address arithmetic: the end of a read and the start of the next page.
    assign read_end  = {1'b0, in_start_reg} + {in_pages_reg, {PAGE_BITS{1'b0}}};
    assign next_page = {1'b0, page_address_reg} + COUNT_W'(PAGE_BYTES);

    assign hdr_col = hdr_addr[PAGE_BITS-1:0];
    assign hdr_row = hdr_addr[ADDR_W-1:PAGE_BITS];

    always_comb
    begin
        phase_next         = phase_reg;
        resetting_next     = resetting_reg;
        page_address_next  = page_address_reg;
        end_address_next   = end_address_reg;
        bytes_in_page_next = bytes_in_page_reg;
        hdr_addr           = in_start_reg;
        use_hdr            = 1'b0;

        // Default is to shift the buffer when the bus takes its front entry.
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i + 1 < MAX_RESULTS)
            begin
                burst_next[i] = rsp_fire ? burst_reg[i + 1] : burst_reg[i];
            end
            else
            begin
                burst_next[i] = burst_reg[i];
            end
        end
        burst_cnt_next = rsp_fire ? burst_cnt_reg - CNT_W'(1) : burst_cnt_reg;

        if (advance)
        begin
            burst_cnt_next = '0;
            case (in_kind_reg)
                REQ_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        burst_next[0] = '{kind: KIND_SELECT, value: '0};
                        if (in_pages_reg == '0)
                        begin
                            burst_next[1]  = '{kind: KIND_DESELECT, value: '0};
                            burst_cnt_next = CNT_W'(2);
                        end
                        else
                        begin
                            page_address_next  = in_start_reg;
                            end_address_next   = read_end;
                            bytes_in_page_next = '0;
                            resetting_next     = 1'b0;
                            hdr_addr           = in_start_reg;
                            use_hdr            = 1'b1;
                            burst_cnt_next     = CNT_W'(MAX_RESULTS);
                            phase_next         = PH_WAIT;
                        end
                    end
                end
                REQ_RESET:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        burst_next[0]  = '{kind: KIND_SELECT, value: '0};
                        burst_next[1]  = '{kind: KIND_CMD, value: CMD_RESET};
                        burst_cnt_next = CNT_W'(2);
                        resetting_next = 1'b1;
                        phase_next     = PH_WAIT;
                    end
                end
                REQ_READY:
                begin
                    if (phase_reg == PH_WAIT && in_ready_reg)
                    begin
                        if (resetting_reg)
                        begin
                            burst_next[0]  = '{kind: KIND_DESELECT, value: '0};
                            burst_cnt_next = CNT_W'(1);
                            resetting_next = 1'b0;
                            phase_next     = PH_IDLE;
                        end
                        else
                        begin
                            bytes_in_page_next = '0;
                            phase_next         = PH_DATA;
                        end
                    end
                end
                REQ_DATA:
                begin
                    if (phase_reg == PH_DATA)
                    begin
                        burst_next[0]      = '{kind: KIND_DATA, value: in_byte_reg};
                        burst_cnt_next     = CNT_W'(1);
                        bytes_in_page_next = bytes_in_page_reg + PAGE_BITS'(1);
                        // Last byte of a page: finish the read or open the next page.
                        if (&bytes_in_page_reg)
                        begin
                            bytes_in_page_next = '0;
                            if (next_page >= end_address_reg)
                            begin
                                burst_next[1]  = '{kind: KIND_DESELECT, value: '0};
                                burst_cnt_next = CNT_W'(2);
                                phase_next     = PH_IDLE;
                            end
                            else
                            begin
                                // Past the top of the address space both the page
                                // and the end wrap down together.
                                if (next_page[ADDR_W])
                                begin
                                    end_address_next = {1'b0, end_address_reg[ADDR_W-1:0]};
                                end
                                page_address_next = next_page[ADDR_W-1:0];
                                hdr_addr          = next_page[ADDR_W-1:0];
                                use_hdr           = 1'b1;
                                burst_cnt_next    = CNT_W'(MAX_RESULTS);
                                phase_next        = PH_WAIT;
                            end
                        end
                    end
                end
                default:
                begin
                    burst_cnt_next = '0;
                end
            endcase

            // The page header always follows one leading bus cycle.
            if (use_hdr)
            begin
                burst_next[1] = '{kind: KIND_CMD,  value: CMD_READ};
                burst_next[2] = '{kind: KIND_ADDR, value: hdr_col[7:0]};
                burst_next[3] = '{kind: KIND_ADDR,
                                  value: BYTE_W'(hdr_col[PAGE_BITS-1:8])};
                burst_next[4] = '{kind: KIND_ADDR, value: hdr_row[7:0]};
                burst_next[5] = '{kind: KIND_ADDR, value: hdr_row[15:8]};
                burst_next[6] = '{kind: KIND_ADDR,
                                  value: BYTE_W'(hdr_row[ROW_W-1:16])};
                burst_next[7] = '{kind: KIND_CMD,  value: CMD_READ_CONFIRM};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            resetting_reg     <= 1'b0;
            page_address_reg  <= '0;
            end_address_reg   <= '0;
            bytes_in_page_reg <= '0;
            burst_cnt_reg     <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            resetting_reg     <= resetting_next;
            page_address_reg  <= page_address_next;
            end_address_reg   <= end_address_next;
            bytes_in_page_reg <= bytes_in_page_next;
            burst_cnt_reg     <= burst_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            burst_reg[i] <= burst_next[i];
        end
    end

`include "nand_page_read_sequencer_core_assert.svh"

    // A burst is never cut short: a stalled or taken non-final entry is followed
    // by another valid entry.
    `NPRS_ASSERT_NEXT(a_burst_continues, rsp.valid && !rsp.last, rsp.valid, "burst cut short")

    // Data is only streamed for reads, never during a reset wait.
    `NPRS_ASSERT_NOW(a_data_not_reset, phase_reg == PH_DATA, !resetting_reg,
        "data phase while resetting")

    // While a read is open the current page lies below the end address.
    `NPRS_ASSERT_NOW(a_page_below_end, phase_reg != PH_IDLE && !resetting_reg,
        ({1'b0, page_address_reg} < end_address_reg), "page address past end")

    // The input side only stalls when the input register holds a request.
    `NPRS_ASSERT_NOW(a_stall_has_item, !req.ready, in_valid_reg, "stall with empty register")

endmodule

`default_nettype wire
